### rtl/core/iplpm_pkg.sv
// shared types and constants for the ipv4 route table
`timescale 1ns / 1ps
package iplpm_pkg;
	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_DEL = 3'd1;
	localparam logic [2:0] FN_LOOKUP = 3'd2;
	localparam logic [2:0] FN_FLUSH = 3'd3;
	localparam logic [2:0] FN_FLUSH_IF = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVAL = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NOROUTE = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [7:0]  iface;
		logic [31:0] gateway;
		logic [31:0] source;
		logic [31:0] flags;
		logic [31:0] metric;
		logic [31:0] order;
	} row_t;

	// prefix mask for a length 0..32
	function automatic logic [31:0] len_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) m = 32'd0;
		else if (len >= 6'd32) m = 32'hFFFF_FFFF;
		else m = 32'hFFFF_FFFF << (6'd32 - len);
		return m;
	endfunction
endpackage

### rtl/core/iplpm_ram.sv
// generic simple dual port ram (separate write and read address) with registered read
`timescale 1ns / 1ps
module iplpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/iplpm_cmp.sv
// shared row compare unit: one stored row against the current request
`timescale 1ns / 1ps
module iplpm_cmp (
	input  iplpm_pkg::row_t      row,
	input  logic                 row_ok,
	input  logic [31:0]          key_addr,
	input  logic [5:0]           key_len,
	input  logic [7:0]           key_iface,
	input  logic [31:0]          key_gw,
	input  logic                 best_ok,
	input  iplpm_pkg::row_t      best,
	output logic                 dup_match,
	output logic                 del_match,
	output logic                 iface_match,
	output logic                 lpm_better
);
	import iplpm_pkg::*;
	logic pfx_eq;
	logic covers;

	// one compare per row, reused for every operation
	always_comb begin
		pfx_eq = row_ok && row.prefix == key_addr && row.len == key_len;
		dup_match = pfx_eq && row.iface == key_iface && row.gateway == key_gw;
		del_match = pfx_eq && (key_iface == 8'd0 || row.iface == key_iface);
		iface_match = row_ok && row.iface == key_iface;
		covers = row_ok && ((key_addr & len_mask(row.len)) == row.prefix);
		if (!covers) lpm_better = 1'b0;
		else if (!best_ok) lpm_better = 1'b1;
		else if (row.len != best.len) lpm_better = row.len > best.len;
		else if (row.metric != best.metric) lpm_better = row.metric < best.metric;
		else lpm_better = row.order < best.order;
	end
endmodule

### rtl/core/ipv4_lpm_route_table.sv
// ipv4 longest prefix match route table, top level
//  channel | dir | handshake            | content
//  s_axis  | in  | tvalid/tready        | tuser=func, tdata=request fields
//  m_axis  | out | tvalid/tready        | tdata=status and lookup results
// every operation runs these steps from accept to result valid:
// mask the key (except for a lookup) and issue the first ram read, pass each row in
// turn through the shared compare unit, then a drain step, a write step and a finish step.
// after the result beat is taken the block returns to idle before it accepts a new
// request.
// reset clears valid bits and counters; row storage needs no clearing.
// the block takes no request until its result beat has been taken.
`timescale 1ns / 1ps
module ipv4_lpm_route_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// dest_addr[31:0] prefix_len[37:32] iface[45:38] gateway[77:46] source_addr[109:78]
	// route_flags[141:110] route_metric[173:142], zero to 175
	input  logic [175:0] s_axis_tdata,
	// func[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0] hit_iface[9:2] hit_nexthop[41:10] hit_source[73:42]
	// hit_flags[105:74] hit_metric[137:106] hit_prefix_len[143:138]
	// removed_count[148:144] generation[180:149], zero to 183
	output logic [183:0] m_axis_tdata
);
	import iplpm_pkg::*;

	state_t state_q, state_d;
	logic [2:0]  func_q;
	logic [31:0] addr_q, gw_q, src_q, flg_q, met_q;
	logic [5:0]  len_q;
	logic [7:0]  if_q;
	logic [IDX_W:0] idx_q;
	logic [ENTRIES-1:0] valid_q;
	logic [31:0] order_q, gen_q;
	logic        rd_ok_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic        same_hit_q, free_hit_q, best_ok_q;
	logic [IDX_W-1:0] same_idx_q, free_idx_q;
	row_t        best_q;
	logic [CNT_W-1:0] rm_q;
	logic [1:0]  st_q;
	logic [183:0] out_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	row_t ram_wdata, ram_rdata;
	logic dup_match, del_match, iface_match, lpm_better;
	logic bad_len;

	logic [4:0]  res_rm;
	logic [7:0]  res_if;
	logic [31:0] res_nh, res_src, res_flg, res_met;
	logic [5:0]  res_len;

	assign ram_raddr = idx_q[IDX_W-1:0];

	iplpm_ram #(.WIDTH($bits(row_t)), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	iplpm_cmp u_cmp (
		.row(ram_rdata), .row_ok(rd_ok_q && valid_q[rd_idx_q]),
		.key_addr(addr_q), .key_len(len_q), .key_iface(if_q), .key_gw(gw_q),
		.best_ok(best_ok_q), .best(best_q),
		.dup_match(dup_match), .del_match(del_match),
		.iface_match(iface_match), .lpm_better(lpm_better)
	);

	assign bad_len = len_q > 6'd32;
	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = state_q == S_OUT;
	assign m_axis_tdata = out_q;

	// add writes one row: update in place or fill first free
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = same_hit_q ? same_idx_q : free_idx_q;
		ram_wdata = '{prefix: addr_q, len: len_q, iface: if_q, gateway: gw_q,
			source: src_q, flags: flg_q, metric: met_q, order: order_q + 32'd1};
		if (same_hit_q) ram_wdata.order = best_q.order;
		if (state_q == S_WRITE && func_q == FN_ADD && st_q == ST_OK
			&& (same_hit_q || free_hit_q)) ram_we = 1'b1;
	end

	// result fields, zero unless the operation reports them
	always_comb begin
		res_rm = '0;
		res_if = '0;
		res_nh = '0;
		res_src = '0;
		res_flg = '0;
		res_met = '0;
		res_len = '0;
		if (func_q == FN_DEL && st_q == ST_OK) res_rm = 5'(rm_q);
		if (func_q == FN_LOOKUP && best_ok_q) begin
			res_if = best_q.iface;
			res_nh = best_q.gateway != 32'd0 ? best_q.gateway : addr_q;
			res_src = best_q.source;
			res_flg = best_q.flags;
			res_met = best_q.metric;
			res_len = best_q.len;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_axis_tvalid) state_d = S_SCAN;
			S_SCAN: if (!rd_ok_q && idx_q == (IDX_W+1)'(ENTRIES)) state_d = S_WRITE;
			S_WRITE: state_d = S_FIN;
			S_FIN: state_d = S_OUT;
			S_OUT: if (m_axis_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			order_q <= '0;
			gen_q <= '0;
			idx_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					rd_ok_q <= 1'b0;
				end
				S_SCAN: begin
					rd_ok_q <= idx_q < (IDX_W+1)'(ENTRIES);
					if (idx_q < (IDX_W+1)'(ENTRIES)) idx_q <= idx_q + 1'b1;
					if (rd_ok_q) begin
						if (func_q == FN_DEL && !bad_len && del_match)
							valid_q[rd_idx_q] <= 1'b0;
						if (func_q == FN_FLUSH_IF && if_q != 8'd0 && iface_match)
							valid_q[rd_idx_q] <= 1'b0;
					end
				end
				S_WRITE: begin
					if (ram_we) begin
						gen_q <= gen_q + 32'd1;
						if (!same_hit_q) begin
							valid_q[free_idx_q] <= 1'b1;
							order_q <= order_q + 32'd1;
						end
					end
					if (func_q == FN_FLUSH) begin
						valid_q <= '0;
						order_q <= '0;
						gen_q <= gen_q + 32'd1;
					end
					if ((func_q == FN_DEL || func_q == FN_FLUSH_IF) && rm_q != '0)
						gen_q <= gen_q + 32'd1;
				end
				default: ;
			endcase
		end
	end

	// request capture, scan bookkeeping and result beat
	always_ff @(posedge clk) begin
		rd_idx_q <= idx_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				func_q <= s_axis_tuser;
				len_q <= s_axis_tdata[37:32];
				addr_q <= s_axis_tdata[31:0];
				if_q <= s_axis_tdata[45:38];
				gw_q <= s_axis_tdata[77:46];
				src_q <= s_axis_tdata[109:78];
				flg_q <= s_axis_tdata[141:110];
				met_q <= s_axis_tdata[173:142];
				same_hit_q <= 1'b0;
				free_hit_q <= 1'b0;
				best_ok_q <= 1'b0;
				rm_q <= '0;
				st_q <= ST_OK;
			end
			S_SCAN: begin
				// mask the key once the request is in, except for a lookup
				if (!rd_ok_q && idx_q == '0 && func_q != FN_LOOKUP)
					addr_q <= addr_q & len_mask(len_q);
				if (rd_ok_q) begin
					if (func_q == FN_ADD && dup_match && !same_hit_q) begin
						same_hit_q <= 1'b1;
						same_idx_q <= rd_idx_q;
						best_q <= ram_rdata;
					end
					if (!valid_q[rd_idx_q] && !free_hit_q) begin
						free_hit_q <= 1'b1;
						free_idx_q <= rd_idx_q;
					end
					if (func_q == FN_LOOKUP && lpm_better) begin
						best_ok_q <= 1'b1;
						best_q <= ram_rdata;
					end
					if ((func_q == FN_DEL && !bad_len && del_match)
						|| (func_q == FN_FLUSH_IF && if_q != 8'd0 && iface_match))
						rm_q <= rm_q + 1'b1;
				end
				if (!rd_ok_q && idx_q == (IDX_W+1)'(ENTRIES)) begin
					case (func_q) inside
						FN_ADD: st_q <= (bad_len || if_q == 8'd0) ? ST_INVAL : ST_OK;
						FN_DEL: st_q <= bad_len ? ST_INVAL : ST_OK;
						FN_LOOKUP, FN_FLUSH, FN_FLUSH_IF: st_q <= ST_OK;
						default: st_q <= ST_INVAL;
					endcase
				end
			end
			S_WRITE: begin
				if (func_q == FN_ADD && st_q == ST_OK && !same_hit_q && !free_hit_q)
					st_q <= ST_FULL;
				if (func_q == FN_DEL && st_q == ST_OK && rm_q == '0) st_q <= ST_NOROUTE;
				if (func_q == FN_LOOKUP && !best_ok_q) st_q <= ST_NOROUTE;
			end
			S_FIN: begin
				out_q <= {3'b000, gen_q, res_rm, res_len, res_met, res_flg, res_src,
					res_nh, res_if, st_q};
			end
			default: ;
		endcase
	end
endmodule
